FILE: rtl/core/indexed_max_priority_task_table_assert.svh
// Assertion macros for the indexed max-priority task table.
// Expects signals named clk and rst_n in the including module.
`ifndef INDEXED_MAX_PRIORITY_TASK_TABLE_ASSERT_SVH
`define INDEXED_MAX_PRIORITY_TASK_TABLE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ITPT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itpt: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define ITPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itpt: next-cycle check failed");

`endif

FILE: rtl/core/itpt_pkg.sv
// Shared types and constants for the indexed max-priority task table.
// No dependencies.
package itpt_pkg;

  localparam int CAPACITY  = 64;
  localparam int SLOT_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_EDIT   = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_EXEC   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_t;

  typedef struct packed {
    req_t        req_type;
    logic [15:0] task_id;
    logic [15:0] user_id;
    logic [31:0] priority_req;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] owner_id;
  } out_item_t;

  // table write command
  typedef struct packed {
    logic                 en_fields;
    logic                 en_prio;
    logic                 set_vld;
    logic                 clr_vld;
    logic [SLOT_BITS-1:0] addr;
    logic [15:0]          task_id;
    logic [15:0]          user_id;
    logic [31:0]          prio;
  } tbl_wr_t;

  // registered table read data
  typedef struct packed {
    logic        vld;
    logic [15:0] task_id;
    logic [15:0] user_id;
    logic [31:0] prio;
  } tbl_rd_t;

  // running search results
  typedef struct packed {
    logic                 match_found;
    logic [SLOT_BITS-1:0] match_slot;
    logic                 free_found;
    logic [SLOT_BITS-1:0] free_slot;
    logic                 best_found;
    logic [SLOT_BITS-1:0] best_slot;
    logic [15:0]          best_user;
  } cmp_res_t;

endpackage

FILE: rtl/core/itpt_table.sv
// Task table storage: task/user/priority memories plus per-slot valid flops.
// Depends on itpt_pkg.
module itpt_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rd_en,
  input  logic [itpt_pkg::SLOT_BITS-1:0] rd_addr,
  output itpt_pkg::tbl_rd_t              rd_data,
  input  itpt_pkg::tbl_wr_t              wr
);

  logic [15:0]                  task_mem [itpt_pkg::CAPACITY];
  logic [15:0]                  user_mem [itpt_pkg::CAPACITY];
  logic [31:0]                  prio_mem [itpt_pkg::CAPACITY];
  logic [itpt_pkg::CAPACITY-1:0] valid_r;
  itpt_pkg::tbl_rd_t            rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en_fields) begin
      task_mem[wr.addr] <= wr.task_id;
      user_mem[wr.addr] <= wr.user_id;
    end
    if (wr.en_prio) begin
      prio_mem[wr.addr] <= wr.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r.vld     <= valid_r[rd_addr];
      rd_data_r.task_id <= task_mem[rd_addr];
      rd_data_r.user_id <= user_mem[rd_addr];
      rd_data_r.prio    <= prio_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (wr.set_vld) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (wr.clr_vld) begin
        valid_r[wr.addr] <= 1'b0;
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/itpt_cmp.sv
// Shared compare unit: while step is high, folds one table entry per cycle into the
// key match, first free slot and best (priority, task id) searches. Depends on itpt_pkg.
module itpt_cmp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           step,
  input  logic [itpt_pkg::SLOT_BITS-1:0] slot,
  input  itpt_pkg::tbl_rd_t              entry,
  input  logic [15:0]                    key,
  output itpt_pkg::cmp_res_t             res
);

  logic                           match_found_r;
  logic [itpt_pkg::SLOT_BITS-1:0] match_slot_r;
  logic                           free_found_r;
  logic [itpt_pkg::SLOT_BITS-1:0] free_slot_r;
  logic                           best_found_r;
  logic [itpt_pkg::SLOT_BITS-1:0] best_slot_r;
  logic [15:0]                    best_user_r;
  logic [15:0]                    best_task_r;
  logic [31:0]                    best_prio_r;
  logic                           hit;
  logic                           better;

  assign hit    = entry.vld && (entry.task_id == key);
  assign better = entry.vld &&
                  (!best_found_r || (entry.prio > best_prio_r) ||
                   ((entry.prio == best_prio_r) && (entry.task_id > best_task_r)));

  // first match / first free slot win; best is replaced only on strict win
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      best_found_r  <= 1'b0;
    end else if (start) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      best_found_r  <= 1'b0;
    end else if (step) begin
      if (hit && !match_found_r) begin
        match_found_r <= 1'b1;
      end
      if (!entry.vld && !free_found_r) begin
        free_found_r <= 1'b1;
      end
      if (better) begin
        best_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (hit && !match_found_r) begin
        match_slot_r <= slot;
      end
      if (!entry.vld && !free_found_r) begin
        free_slot_r <= slot;
      end
      if (better) begin
        best_slot_r <= slot;
        best_user_r <= entry.user_id;
        best_task_r <= entry.task_id;
        best_prio_r <= entry.prio;
      end
    end
  end

  assign res.match_found = match_found_r;
  assign res.match_slot  = match_slot_r;
  assign res.free_found  = free_found_r;
  assign res.free_slot   = free_slot_r;
  assign res.best_found  = best_found_r;
  assign res.best_slot   = best_slot_r;
  assign res.best_user   = best_user_r;

endmodule

FILE: rtl/core/indexed_max_priority_task_table.sv
// Indexed max-priority task table, top level: sequencer and result register.
// Depends on itpt_pkg, itpt_table, itpt_cmp and the assertion macro header.
//
// Holds up to itpt_pkg::CAPACITY tasks (task id, user id, priority). Each
// transaction is add, edit priority, remove or execute top, and yields exactly
// one result transaction. A request passes from acceptance in idle through a
// scan of every slot, which also drains the table read pipeline, to the update
// state, and its result then waits for out_ready; in_ready is high only while
// the block is idle. The scan sets the pace: the table has one read port and
// every request walks all slots through it, one slot per cycle, into a shared
// compare unit. Add overwrites an existing id in place, else takes the lowest
// free slot, else reports full. Edit/remove of an absent id reports not
// found. Execute top picks the highest priority, ties going to the larger task
// id, removes it and returns its user id; an empty table reports empty with
// owner zero.
`include "indexed_max_priority_task_table_assert.svh"

module indexed_max_priority_task_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  itpt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output itpt_pkg::out_item_t out_data
);

  itpt_pkg::state_t               state_r, state_nxt;
  logic [itpt_pkg::CNT_BITS-1:0]  idx_r, idx_nxt;
  logic                           rd_vld_r, rd_vld_nxt;
  logic [itpt_pkg::SLOT_BITS-1:0] rd_slot_r;
  logic                           out_valid_r, out_valid_nxt;
  itpt_pkg::out_item_t            out_data_r, out_data_nxt;
  itpt_pkg::in_item_t             req_r;

  logic                           rd_en;
  logic                           cmp_start;
  itpt_pkg::tbl_wr_t              tbl_wr;
  itpt_pkg::tbl_rd_t              tbl_rd;
  itpt_pkg::cmp_res_t             cmp_res;

  // Storage: one read port used by the scan, one write port used by update.
  itpt_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (idx_r[itpt_pkg::SLOT_BITS-1:0]),
    .rd_data (tbl_rd),
    .wr      (tbl_wr)
  );

  // Compare unit sees each slot in the cycle after its read is issued.
  itpt_cmp u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmp_start),
    .step  (rd_vld_r),
    .slot  (rd_slot_r),
    .entry (tbl_rd),
    .key   (req_r.task_id),
    .res   (cmp_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itpt_pkg::ST_IDLE;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    rd_slot_r  <= idx_r[itpt_pkg::SLOT_BITS-1:0];
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    rd_vld_nxt     = 1'b0;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    in_ready       = 1'b0;
    rd_en          = 1'b0;
    cmp_start      = 1'b0;
    tbl_wr         = '0;
    tbl_wr.task_id = req_r.task_id;
    tbl_wr.user_id = req_r.user_id;
    tbl_wr.prio    = req_r.priority_req;

    unique case (state_r)
      itpt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmp_start = 1'b1;
          idx_nxt   = '0;
          state_nxt = itpt_pkg::ST_SCAN;
        end
      end

      // issue one slot read per cycle; the last read lands while idx == CAPACITY
      itpt_pkg::ST_SCAN: begin
        if (idx_r != itpt_pkg::CNT_BITS'(itpt_pkg::CAPACITY)) begin
          rd_en      = 1'b1;
          rd_vld_nxt = 1'b1;
          idx_nxt    = idx_r + itpt_pkg::CNT_BITS'(1);
        end else begin
          state_nxt = itpt_pkg::ST_UPDATE;
        end
      end

      // apply the request using the finished search results
      itpt_pkg::ST_UPDATE: begin
        out_data_nxt.status   = itpt_pkg::STATUS_OK;
        out_data_nxt.owner_id = '0;
        case (req_r.req_type)
          itpt_pkg::REQ_ADD: begin
            if (cmp_res.match_found || cmp_res.free_found) begin
              tbl_wr.en_fields = 1'b1;
              tbl_wr.en_prio   = 1'b1;
              tbl_wr.set_vld   = 1'b1;
              tbl_wr.addr      = cmp_res.match_found ? cmp_res.match_slot
                                                     : cmp_res.free_slot;
            end else begin
              out_data_nxt.status = itpt_pkg::STATUS_FULL;
            end
          end
          itpt_pkg::REQ_EDIT: begin
            if (cmp_res.match_found) begin
              tbl_wr.en_prio = 1'b1;
              tbl_wr.addr    = cmp_res.match_slot;
            end else begin
              out_data_nxt.status = itpt_pkg::STATUS_NOT_FOUND;
            end
          end
          itpt_pkg::REQ_REMOVE: begin
            if (cmp_res.match_found) begin
              tbl_wr.clr_vld = 1'b1;
              tbl_wr.addr    = cmp_res.match_slot;
            end else begin
              out_data_nxt.status = itpt_pkg::STATUS_NOT_FOUND;
            end
          end
          default: begin
            if (cmp_res.best_found) begin
              tbl_wr.clr_vld        = 1'b1;
              tbl_wr.addr           = cmp_res.best_slot;
              out_data_nxt.owner_id = cmp_res.best_user;
            end else begin
              out_data_nxt.status = itpt_pkg::STATUS_EMPTY;
            end
          end
        endcase
        out_valid_nxt = 1'b1;
        state_nxt     = itpt_pkg::ST_RESP;
      end

      itpt_pkg::ST_RESP: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = itpt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = itpt_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // One request in flight: never idle with a result pending.
  `ITPT_ASSERT_SAME(a_ready_no_result, in_ready, !out_valid)
  // Read data only arrives during the scan.
  `ITPT_ASSERT_SAME(a_rd_in_scan, rd_vld_r, state_r == itpt_pkg::ST_SCAN)
  // Taking the result returns the block to idle.
  `ITPT_ASSERT_NEXT(a_ready_after_out, out_valid && out_ready, in_ready)
  // Owner is only reported with an ok status.
  `ITPT_ASSERT_SAME(a_owner_zero, out_valid && (out_data.status != itpt_pkg::STATUS_OK), out_data.owner_id == 16'd0)

endmodule

FILE: sim/task_table_checker.sv
// Result checker for the indexed max-priority task table: watches both channels,
// keeps its own copy of the task table and compares every result transaction.
// Depends on itpt_pkg.
module task_table_checker
  import itpt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        results_pending,
  output int        results_checked,
  output int        full_seen,
  output int        empty_seen,
  output int        not_found_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow task table
  logic        slot_used  [CAPACITY];
  logic [15:0] slot_task  [CAPACITY];
  logic [15:0] slot_owner [CAPACITY];
  logic [31:0] slot_prio  [CAPACITY];

  out_item_t expected_results[$];
  out_item_t oldest;

  // Applies one request to the shadow table and returns the result it yields.
  function automatic out_item_t apply_request(in_item_t rq);
    out_item_t rsp;
    int        hit;
    int        spare;
    int        top;
    rsp.status   = STATUS_OK;
    rsp.owner_id = '0;
    hit   = -1;
    spare = -1;
    top   = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot_used[i] && slot_task[i] == rq.task_id && hit < 0) hit = i;
      if (!slot_used[i] && spare < 0) spare = i;
      if (slot_used[i] && (top < 0 || slot_prio[i] > slot_prio[top] ||
          (slot_prio[i] == slot_prio[top] && slot_task[i] > slot_task[top])))
        top = i;
    end
    case (rq.req_type)
      REQ_ADD: begin
        if (hit < 0) hit = spare;
        if (hit < 0) begin
          rsp.status = STATUS_FULL;
        end else begin
          slot_used[hit]  = 1'b1;
          slot_task[hit]  = rq.task_id;
          slot_owner[hit] = rq.user_id;
          slot_prio[hit]  = rq.priority_req;
        end
      end
      REQ_EDIT: begin
        if (hit < 0) rsp.status = STATUS_NOT_FOUND;
        else slot_prio[hit] = rq.priority_req;
      end
      REQ_REMOVE: begin
        if (hit < 0) rsp.status = STATUS_NOT_FOUND;
        else slot_used[hit] = 1'b0;
      end
      default: begin
        if (top < 0) begin
          rsp.status = STATUS_EMPTY;
        end else begin
          rsp.owner_id   = slot_owner[top];
          slot_used[top] = 1'b0;
        end
      end
    endcase
    return rsp;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CAPACITY; i++) slot_used[i] = 1'b0;
      expected_results.delete();
      fail_count      <= 0;
      results_pending <= 0;
      results_checked <= 0;
      full_seen       <= 0;
      empty_seen      <= 0;
      not_found_seen  <= 0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(apply_request(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request waiting: status %0d owner %h",
                   $time, out_data.status, out_data.owner_id);
          fail_count <= fail_count + 1;
        end else begin
          oldest = expected_results.pop_front();
          results_checked <= results_checked + 1;
          if (oldest.status == STATUS_FULL) full_seen <= full_seen + 1;
          if (oldest.status == STATUS_EMPTY) empty_seen <= empty_seen + 1;
          if (oldest.status == STATUS_NOT_FOUND) not_found_seen <= not_found_seen + 1;
          if (out_data.status !== oldest.status || out_data.owner_id !== oldest.owner_id) begin
            $display("%0t: result mismatch: expected status %0d owner %h, got status %0d owner %h",
                     $time, oldest.status, oldest.owner_id, out_data.status, out_data.owner_id);
            fail_count <= fail_count + 1;
          end
        end
      end
      results_pending <= expected_results.size();
    end
  end

endmodule

FILE: sim/testbench.sv
// Top of the task table regression: clock, reset, request stimulus, result-side
// stalls, watchdog and verdict. Depends on itpt_pkg, task_table_checker and the RTL.
module testbench;
  import itpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Random part length; the directed opener adds about twenty more requests.
  localparam int RANDOM_ITEMS = 930;
  // Quiet cycles allowed: this is several times over one scan, the longest sender
  // gap and the longest receiver stall.
  localparam int QUIET_LIMIT  = 2000;

  // Request mixes used by the random part, visited in turn.
  typedef enum int {
    MIX_FILL,   // mostly adds over a narrow id window: drives the table to full
    MIX_CHURN,  // balanced traffic on the same window: overwrites, edits, hits
    MIX_DRAIN,  // mostly execute top: empties the table
    MIX_WIDE    // any id at all: mostly misses, toggles every id bit
  } mix_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int fail_count;
  int results_pending;
  int results_checked;
  int full_seen;
  int empty_seen;
  int not_found_seen;
  int requests_sent;
  int quiet_cycles;
  int ready_hold;

  indexed_max_priority_task_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  task_table_checker table_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .results_pending(results_pending),
    .results_checked(results_checked),
    .full_seen      (full_seen),
    .empty_seen     (empty_seen),
    .not_found_seen (not_found_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result-side back pressure: ready alternates between runs of random length.
  // Now and then a long ready run gives stretches with no stall at all.
  initial begin
    out_ready  = 1'b0;
    ready_hold = 0;
  end

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 24);
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300)
                                                : $urandom_range(0, 40);
    end
  end

  // Watchdog: any transaction on either channel resets the quiet count.
  initial quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("indexed_max_priority_task_table regression: fail");
        $finish;
      end
    end
  end

  function automatic in_item_t make_request(req_t kind, logic [15:0] id,
                                            logic [15:0] user, logic [31:0] prio);
    in_item_t rq;
    rq.req_type     = kind;
    rq.task_id      = id;
    rq.user_id      = user;
    rq.priority_req = prio;
    return rq;
  endfunction

  // One random request. Ids mostly come from a 128-wide window so that adds,
  // edits and removes hit live entries; small priorities force ties.
  function automatic in_item_t random_request(mix_t mix, logic [15:0] base);
    in_item_t rq;
    int       roll;
    int       add_w;
    int       edit_w;
    int       rm_w;
    case (mix)
      MIX_FILL:  begin add_w = 85; edit_w = 5;  rm_w = 5;  end
      MIX_CHURN: begin add_w = 35; edit_w = 25; rm_w = 20; end
      MIX_DRAIN: begin add_w = 10; edit_w = 10; rm_w = 10; end
      default:   begin add_w = 25; edit_w = 25; rm_w = 25; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < add_w) rq.req_type = REQ_ADD;
    else if (roll < add_w + edit_w) rq.req_type = REQ_EDIT;
    else if (roll < add_w + edit_w + rm_w) rq.req_type = REQ_REMOVE;
    else rq.req_type = REQ_EXEC;

    if (mix == MIX_WIDE || $urandom_range(0, 19) == 0)
      rq.task_id = 16'($urandom_range(0, 65535));
    else rq.task_id = base + 16'($urandom_range(0, 127));
    rq.user_id = 16'($urandom_range(0, 65535));

    roll = $urandom_range(0, 9);
    if (roll < 4) rq.priority_req = $urandom_range(0, 3);
    else if (roll == 4) rq.priority_req = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
    else rq.priority_req = $urandom;
    return rq;
  endfunction

  // Presents one request and returns at the edge where it is accepted;
  // valid stays up so a back-to-back request needs no second assignment.
  task automatic send_request(in_item_t rq);
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  initial begin : stimulus
    mix_t        mix;
    logic [15:0] window_base;
    int          random_sent;
    int          run_len;
    int          burst_left;
    int          gap;

    requests_sent = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opener: misses on an empty table, field extremes, overwrite,
    // the tie on equal priority, edits that reorder, and draining to empty.
    send_request(make_request(REQ_EXEC,   16'h0000, 16'h0000, 32'h0));
    send_request(make_request(REQ_EDIT,   16'h1234, 16'hBEEF, 32'h55));
    send_request(make_request(REQ_REMOVE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_request(make_request(REQ_ADD,    16'h0000, 16'h0000, 32'h0));
    send_request(make_request(REQ_ADD,    16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_request(make_request(REQ_ADD,    16'h00A5, 16'h1111, 32'h10));
    send_request(make_request(REQ_ADD,    16'h00A5, 16'h2222, 32'h20)); // overwrite in place
    send_request(make_request(REQ_ADD,    16'h5A00, 16'h3333, 32'h20)); // ties with 00A5
    send_request(make_request(REQ_EDIT,   16'hFFFF, 16'h9999, 32'h0));
    send_request(make_request(REQ_EXEC,   16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF)); // larger id wins
    send_request(make_request(REQ_EXEC,   16'h0000, 16'h0000, 32'h0));
    send_request(make_request(REQ_REMOVE, 16'h0000, 16'h7777, 32'h1));
    send_request(make_request(REQ_EDIT,   16'h0000, 16'h0000, 32'h8));      // gone now
    send_request(make_request(REQ_ADD,    16'h8000, 16'hAAAA, 32'h8000_0000));
    send_request(make_request(REQ_ADD,    16'h7FFF, 16'h5555, 32'h7FFF_FFFF));
    send_request(make_request(REQ_EDIT,   16'h7FFF, 16'h0000, 32'hFFFF_FFFF));
    send_request(make_request(REQ_REMOVE, 16'h8001, 16'h0000, 32'h0));      // near miss
    send_request(make_request(REQ_EXEC,   16'h0000, 16'h0000, 32'h0));
    send_request(make_request(REQ_EXEC,   16'h0000, 16'h0000, 32'h0));
    send_request(make_request(REQ_EXEC,   16'h0000, 16'h0000, 32'h0));
    send_request(make_request(REQ_EXEC,   16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF)); // empty again

    // Random part: runs of one mix at a time, sent in bursts. Gaps are mostly
    // short (swallowed by the scan) but some outlast a whole request, so the
    // block also sits idle or holds a result while valid is low.
    mix         = MIX_FILL;
    random_sent = 0;
    burst_left  = $urandom_range(1, 12);
    while (random_sent < RANDOM_ITEMS) begin
      window_base = 16'($urandom_range(0, 65535 - 127));
      run_len     = $urandom_range(80, 160);
      for (int k = 0; k < run_len && random_sent < RANDOM_ITEMS; k++) begin
        send_request(random_request(mix, window_base));
        random_sent++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gap = 0;
            5, 6, 7:       gap = $urandom_range(1, 8);
            default:       gap = $urandom_range(55, 100);
          endcase
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
      mix = mix.next();
    end
    if (burst_left != 0) in_valid <= 1'b0;
    if (burst_left == 0) in_valid <= 1'b0;

    // Drain: wait for every expected result, then a scan's worth of cycles
    // so a stray extra result would still be seen.
    do @(posedge clk); while (results_pending != 0);
    repeat (CAPACITY + 8) @(posedge clk);

    $display("%0d requests driven, %0d results checked", requests_sent, results_checked);
    $display("outcomes seen: %0d table full, %0d empty, %0d not found",
             full_seen, empty_seen, not_found_seen);
    if (fail_count == 0 && results_pending == 0) begin
      $display("indexed_max_priority_task_table regression: pass");
    end else begin
      $display("indexed_max_priority_task_table regression: fail");
    end
    $finish;
  end

endmodule
